// ===== hw/rtl/tapfc_pkg.sv =====
package tapfc_pkg;

	// Field and register widths
	localparam int VAL_W     = 32;
	localparam int GAIN_W    = 32;
	localparam int LIM_W     = 31;
	localparam int DT_W      = 24;
	localparam int FRAC_W    = 16;
	localparam int CFG_IDX_W = 4;

	// Exact error and floored product term widths
	localparam int ERR_W    = VAL_W + 1;
	localparam int P_FULL_W = GAIN_W + 1 + ERR_W;
	localparam int T_FULL_W = DT_W + 1 + ERR_W;
	localparam int I_FULL_W = GAIN_W + 1 + VAL_W;
	localparam int P_TERM_W = P_FULL_W - 1 - FRAC_W;
	localparam int T_TERM_W = T_FULL_W - 1 - FRAC_W;
	localparam int I_TERM_W = I_FULL_W - 1 - FRAC_W;
	localparam int SUM_W    = P_TERM_W + 1;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIN_P_GAIN    = 4'd0,
		REG_LIN_I_GAIN    = 4'd1,
		REG_LIN_INT_LIMIT = 4'd2,
		REG_FORCE_LIMIT   = 4'd3,
		REG_ANG_P_GAIN    = 4'd4,
		REG_ANG_I_GAIN    = 4'd5,
		REG_ANG_INT_LIMIT = 4'd6,
		REG_TORQUE_LIMIT  = 4'd7
	} cfg_reg_t;

	// Register reset values
	localparam logic [GAIN_W-1:0] LIN_P_GAIN_RST    = 32'd65536000;
	localparam logic [GAIN_W-1:0] LIN_I_GAIN_RST    = 32'd0;
	localparam logic [LIM_W-1:0]  LIN_INT_LIMIT_RST = 31'd65536;
	localparam logic [LIM_W-1:0]  FORCE_LIMIT_RST   = 31'd65536;
	localparam logic [GAIN_W-1:0] ANG_P_GAIN_RST    = 32'd6553600;
	localparam logic [GAIN_W-1:0] ANG_I_GAIN_RST    = 32'd0;
	localparam logic [LIM_W-1:0]  ANG_INT_LIMIT_RST = 31'd65536;
	localparam logic [LIM_W-1:0]  TORQUE_LIMIT_RST  = 31'd65536;

	// Gains and limits of one axis
	typedef struct packed {
		logic [GAIN_W-1:0] p_gain;
		logic [GAIN_W-1:0] i_gain;
		logic [LIM_W-1:0]  int_limit;
		logic [LIM_W-1:0]  drive_limit;
	} axis_cfg_t;

	// Pipeline control shared by the axes
	typedef struct packed {
		logic adv;
		logic integ_upd;
	} axis_ctl_t;

	// Clamp a wide signed value to plus or minus an unsigned limit
	function automatic logic signed [VAL_W-1:0] sat_sym(
		input logic signed [SUM_W-1:0] v,
		input logic [LIM_W-1:0] lim
	);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = $signed({{(SUM_W-LIM_W){1'b0}}, lim});
		lo = -hi;
		if (v > hi) begin
			sat_sym = hi[VAL_W-1:0];
		end else if (v < lo) begin
			sat_sym = lo[VAL_W-1:0];
		end else begin
			sat_sym = v[VAL_W-1:0];
		end
	endfunction

endpackage

// ===== hw/rtl/three_axis_pi_force_controller_unit.sv =====
// Three-axis PI force controller. Each transfer on the input channel is one control
// tick; it yields exactly one result (force_x, force_y, torque_z), and a new tick
// is taken every cycle while the output side keeps up: the four
// register levels (input, product, integral term, result) advance together and stall
// only while a result waits to be taken. Per axis the drive is P*error plus I times
// the integrator from before the tick, clamped to the drive limit; the integrator
// then gains error*tick_seconds and is clamped to its own limit. Products are
// floored to Q16.16. The configuration port is always ready; write registers only
// while no tick is in flight. Unknown register indexes are ignored.
module three_axis_pi_force_controller_unit import tapfc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [GAIN_W-1:0]           cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [VAL_W-1:0]     target_vx,
	input  logic signed [VAL_W-1:0]     target_vy,
	input  logic signed [VAL_W-1:0]     target_wz,
	input  logic signed [VAL_W-1:0]     measured_vx,
	input  logic signed [VAL_W-1:0]     measured_vy,
	input  logic signed [VAL_W-1:0]     measured_wz,
	input  logic [DT_W-1:0]             tick_seconds,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [VAL_W-1:0]     force_x,
	output logic signed [VAL_W-1:0]     force_y,
	output logic signed [VAL_W-1:0]     torque_z
);

	logic [GAIN_W-1:0] lin_p_gain_q;
	logic [GAIN_W-1:0] lin_i_gain_q;
	logic [LIM_W-1:0]  lin_int_limit_q;
	logic [LIM_W-1:0]  force_limit_q;
	logic [GAIN_W-1:0] ang_p_gain_q;
	logic [GAIN_W-1:0] ang_i_gain_q;
	logic [LIM_W-1:0]  ang_int_limit_q;
	logic [LIM_W-1:0]  torque_limit_q;
	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	logic              out_valid_q;
	logic              adv;
	axis_ctl_t         ctl;
	axis_cfg_t         lin_cfg;
	axis_cfg_t         ang_cfg;

	assign cfg_ready = 1'b1;

	// Register writes; drop bits above each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_p_gain_q    <= LIN_P_GAIN_RST;
			lin_i_gain_q    <= LIN_I_GAIN_RST;
			lin_int_limit_q <= LIN_INT_LIMIT_RST;
			force_limit_q   <= FORCE_LIMIT_RST;
			ang_p_gain_q    <= ANG_P_GAIN_RST;
			ang_i_gain_q    <= ANG_I_GAIN_RST;
			ang_int_limit_q <= ANG_INT_LIMIT_RST;
			torque_limit_q  <= TORQUE_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_LIN_P_GAIN:    lin_p_gain_q    <= cfg_data;
				REG_LIN_I_GAIN:    lin_i_gain_q    <= cfg_data;
				REG_LIN_INT_LIMIT: lin_int_limit_q <= cfg_data[LIM_W-1:0];
				REG_FORCE_LIMIT:   force_limit_q   <= cfg_data[LIM_W-1:0];
				REG_ANG_P_GAIN:    ang_p_gain_q    <= cfg_data;
				REG_ANG_I_GAIN:    ang_i_gain_q    <= cfg_data;
				REG_ANG_INT_LIMIT: ang_int_limit_q <= cfg_data[LIM_W-1:0];
				REG_TORQUE_LIMIT:  torque_limit_q  <= cfg_data[LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Whole pipeline advances unless a result is held back
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	assign out_valid     = out_valid_q;
	assign ctl.adv       = adv;
	assign ctl.integ_upd = adv && valid_s2;

	assign lin_cfg = '{p_gain: lin_p_gain_q, i_gain: lin_i_gain_q,
		int_limit: lin_int_limit_q, drive_limit: force_limit_q};
	assign ang_cfg = '{p_gain: ang_p_gain_q, i_gain: ang_i_gain_q,
		int_limit: ang_int_limit_q, drive_limit: torque_limit_q};

	tapfc_axis u_axis_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cfg      (lin_cfg),
		.target   (target_vx),
		.measured (measured_vx),
		.dt       (tick_seconds),
		.drive    (force_x)
	);

	tapfc_axis u_axis_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cfg      (lin_cfg),
		.target   (target_vy),
		.measured (measured_vy),
		.dt       (tick_seconds),
		.drive    (force_y)
	);

	tapfc_axis u_axis_w (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cfg      (ang_cfg),
		.target   (target_wz),
		.measured (measured_wz),
		.dt       (tick_seconds),
		.drive    (torque_z)
	);

`ifndef SYNTHESIS
	// force_x and torque_z never exceed their configured limits
	a_force_x_lim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (force_x <= $signed({1'b0, force_limit_q}))
			&& (force_x >= -$signed({1'b0, force_limit_q})))
		else $error("force_x beyond force_limit");

	a_torque_lim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (torque_z <= $signed({1'b0, torque_limit_q}))
			&& (torque_z >= -$signed({1'b0, torque_limit_q})))
		else $error("torque_z beyond torque_limit");

	// A held result stays valid and keeps force_x and torque_z while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(force_x) && $stable(torque_z))
		else $error("stalled result changed");

	// A tick taken into an empty pipeline reaches out_valid while out_ready stays high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !valid_s1 && !valid_s2 && !valid_s3 && out_ready
			##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("result lost in pipeline");
`endif

endmodule

// ===== hw/rtl/tapfc_axis.sv =====
module tapfc_axis import tapfc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  axis_ctl_t               ctl,
	input  axis_cfg_t               cfg,
	input  logic signed [VAL_W-1:0] target,
	input  logic signed [VAL_W-1:0] measured,
	input  logic [DT_W-1:0]         dt,
	output logic signed [VAL_W-1:0] drive
);

	logic signed [VAL_W-1:0]    target_s1;
	logic signed [VAL_W-1:0]    measured_s1;
	logic [DT_W-1:0]            dt_s1;
	logic signed [ERR_W-1:0]    err;
	logic signed [P_FULL_W-1:0] p_full;
	logic signed [T_FULL_W-1:0] t_full;
	logic signed [P_TERM_W-1:0] p_term_s2;
	logic signed [T_TERM_W-1:0] t_term_s2;
	logic signed [VAL_W-1:0]    integ_q;
	logic signed [I_FULL_W-1:0] i_full;
	logic signed [SUM_W-1:0]    integ_sum;
	logic signed [P_TERM_W-1:0] p_term_s3;
	logic signed [I_TERM_W-1:0] i_term_s3;
	logic signed [SUM_W-1:0]    drive_sum;
	logic signed [VAL_W-1:0]    drive_q;

	// Stage 1: capture the transfer
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			target_s1   <= target;
			measured_s1 <= measured;
			dt_s1       <= dt;
		end
	end

	// Exact error and the two products that depend on it alone
	assign err    = {target_s1[VAL_W-1], target_s1} - {measured_s1[VAL_W-1], measured_s1};
	assign p_full = $signed({1'b0, cfg.p_gain}) * err;
	assign t_full = $signed({1'b0, dt_s1}) * err;

	// Stage 2: hold the floored products
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			p_term_s2 <= p_full[P_TERM_W+FRAC_W-1:FRAC_W];
			t_term_s2 <= t_full[T_TERM_W+FRAC_W-1:FRAC_W];
		end
	end

	// Integral term uses the integrator from before this tick
	assign i_full    = $signed({1'b0, cfg.i_gain}) * integ_q;
	assign integ_sum = {{(SUM_W-VAL_W){integ_q[VAL_W-1]}}, integ_q}
		+ {{(SUM_W-T_TERM_W){t_term_s2[T_TERM_W-1]}}, t_term_s2};

	// Advance the integrator with anti-windup clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (ctl.integ_upd) begin
			integ_q <= sat_sym(integ_sum, cfg.int_limit);
		end
	end

	// Stage 3: hold both drive terms
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			p_term_s3 <= p_term_s2;
			i_term_s3 <= i_full[I_TERM_W+FRAC_W-1:FRAC_W];
		end
	end

	assign drive_sum = {p_term_s3[P_TERM_W-1], p_term_s3}
		+ {{(SUM_W-I_TERM_W){i_term_s3[I_TERM_W-1]}}, i_term_s3};

	// Result register: clamped drive
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			drive_q <= sat_sym(drive_sum, cfg.drive_limit);
		end
	end

	assign drive = drive_q;

endmodule
